### design/lvhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhc_pkg
// Shared types and constants of the level to hue colour map pipeline.
// ----------------------------------------------------------------------------
package lvhc_pkg;

  // Width of the normalized fraction; all ones stands for 1.0.
  localparam int FracBits = 16;

  // Hue is held in degrees with 8 fractional bits.
  localparam int HueW       = 17;
  localparam int SectorQ8   = 15360;
  localparam int FullTurnQ8 = 92160;
  localparam int XfW        = 14;

  // 60 degrees in Q8 is 15 * 1024, so the low 10 bits divide out exactly.
  localparam int SectorShift = 10;
  localparam int SectorUnit  = 15;

  // Channel divisor after the shift: 255 * 15, and its scaled reciprocal.
  localparam int ChanDiv    = 3825;
  localparam int RecipK     = 17544;
  localparam int RecipShift = 26;
  localparam int ChanW      = 20;

  typedef enum logic [2:0] {
    REG_RANGE_LOW  = 3'd0,
    REG_RANGE_HIGH = 3'd1,
    REG_HUE_START  = 3'd2,
    REG_HUE_END    = 3'd3,
    REG_SATURATION = 3'd4,
    REG_BRIGHTNESS = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic                valid;
    logic [FracBits-1:0] frac;
    logic                clamped;
    logic                range_invalid;
  } norm_hue_t;

  typedef struct packed {
    logic           valid;
    sector_e        sector;
    logic [XfW-1:0] xf;
    logic           clamped;
    logic           range_invalid;
  } hue_rgb_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
    logic       range_invalid;
  } rgb_out_t;

endpackage

### design/lvhc_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhc_norm
// Range check and normalization of a sample to a 16-bit fraction through a
// pipelined restoring divider that retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module lvhc_norm #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   in_valid_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] range_low_i,
  input  logic [SAMPLE_BITS-1:0] range_high_i,
  output lvhc_pkg::norm_hue_t    out_o
);
  import lvhc_pkg::*;

  localparam int NumW = SAMPLE_BITS + FracBits;

  logic [FracBits:0]         vld_q, vld_d;
  logic [FracBits:0]         clp_q, clp_d;
  logic [FracBits:0]         inv_q, inv_d;
  logic [SAMPLE_BITS-1:0]    rem_q [FracBits+1];
  logic [SAMPLE_BITS-1:0]    rem_d [FracBits+1];
  logic [SAMPLE_BITS-1:0]    den_q [FracBits+1];
  logic [SAMPLE_BITS-1:0]    den_d [FracBits+1];
  logic [FracBits-1:0]       nlo_q [FracBits+1];
  logic [FracBits-1:0]       nlo_d [FracBits+1];
  logic [FracBits-1:0]       quo_q [FracBits+1];
  logic [FracBits-1:0]       quo_d [FracBits+1];

  always_comb begin
    logic                   is_inv;
    logic                   below;
    logic                   above;
    logic [SAMPLE_BITS-1:0] diff;
    logic [NumW-1:0]        num;
    logic [SAMPLE_BITS:0]   trial;
    logic                   ge;

    is_inv = (range_high_i <= range_low_i);
    below  = (sample_i < range_low_i);
    above  = (sample_i > range_high_i);
    diff   = sample_i - range_low_i;
    // diff * 65535 written as diff * 65536 - diff.
    num    = {diff, {FracBits{1'b0}}} - {{FracBits{1'b0}}, diff};

    vld_d[0] = in_valid_i;
    inv_d[0] = is_inv;
    clp_d[0] = !is_inv && (below || above);
    quo_d[0] = '0;
    if (is_inv || below) begin
      rem_d[0] = '0;
      den_d[0] = SAMPLE_BITS'(1);
      nlo_d[0] = '0;
    end else if (above) begin
      // Dividing all ones by one yields the full-scale fraction.
      rem_d[0] = '0;
      den_d[0] = SAMPLE_BITS'(1);
      nlo_d[0] = '1;
    end else begin
      rem_d[0] = num[NumW-1:FracBits];
      den_d[0] = range_high_i - range_low_i;
      nlo_d[0] = num[FracBits-1:0];
    end

    for (int k = 1; k <= FracBits; k++) begin
      trial    = {rem_q[k-1], nlo_q[k-1][FracBits-1]};
      ge       = (trial >= {1'b0, den_q[k-1]});
      rem_d[k] = ge ? SAMPLE_BITS'(trial - {1'b0, den_q[k-1]}) : trial[SAMPLE_BITS-1:0];
      den_d[k] = den_q[k-1];
      nlo_d[k] = {nlo_q[k-1][FracBits-2:0], 1'b0};
      quo_d[k] = {quo_q[k-1][FracBits-2:0], ge};
      vld_d[k] = vld_q[k-1];
      clp_d[k] = clp_q[k-1];
      inv_d[k] = inv_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clp_q <= clp_d;
      inv_q <= inv_d;
      rem_q <= rem_d;
      den_q <= den_d;
      nlo_q <= nlo_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    out_o.valid         = vld_q[FracBits];
    out_o.frac          = quo_q[FracBits];
    out_o.clamped       = clp_q[FracBits];
    out_o.range_invalid = inv_q[FracBits];
  end

endmodule

### design/lvhc_hue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhc_hue
// Maps the fraction onto the configured hue span, wraps it to one turn and
// splits it into a 60-degree sector and the secondary-component weight.
// ----------------------------------------------------------------------------
module lvhc_hue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  lvhc_pkg::norm_hue_t in_i,
  input  logic [8:0]          hue_start_i,
  input  logic [8:0]          hue_end_i,
  output lvhc_pkg::hue_rgb_t  out_o
);
  import lvhc_pkg::*;

  localparam int NumStages = 5;
  localparam int ProdW     = 25;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] clp_q;
  logic [NumStages-1:0] inv_q;

  logic [ProdW-1:0] prod_q, prod_d;
  logic [HueW-1:0]  off_q, off_d;
  logic [HueW-1:0]  hsum_q, hsum_d;
  logic [HueW-1:0]  hue_q, hue_d;
  sector_e          sec_q, sec_d;
  logic [XfW-1:0]   xf_q, xf_d;

  // Stage 1: span times fraction.
  always_comb begin
    logic [8:0] span;
    span   = (hue_end_i >= hue_start_i) ? (hue_end_i - hue_start_i)
                                        : (hue_start_i - hue_end_i);
    prod_d = ProdW'(span) * ProdW'(in_i.frac);
  end

  // Stage 2: floor(prod * 256 / 65535) by the 2^16 - 1 folding trick.
  always_comb begin
    logic [HueW-1:0] q0;
    logic [17:0]     rfold;
    q0    = prod_q[ProdW-1:8];
    rfold = 18'({prod_q[7:0], 8'h00}) + 18'(q0);
    if (rfold >= 18'(2 * ((1 << FracBits) - 1))) begin
      off_d = q0 + HueW'(2);
    end else if (rfold >= 18'((1 << FracBits) - 1)) begin
      off_d = q0 + HueW'(1);
    end else begin
      off_d = q0;
    end
  end

  // Stage 3: offset applied toward the end hue.
  always_comb begin
    logic [HueW-1:0] base;
    base   = {hue_start_i, 8'h00};
    hsum_d = (hue_end_i >= hue_start_i) ? (base + off_q) : (base - off_q);
  end

  // Stage 4: one wrap is enough since the sum stays below two turns.
  always_comb begin
    hue_d = (hsum_q >= HueW'(FullTurnQ8)) ? (hsum_q - HueW'(FullTurnQ8)) : hsum_q;
  end

  // Stage 5: sector and the weight of the secondary component.
  always_comb begin
    logic [HueW-1:0] sbase;
    logic [XfW-1:0]  h_in;
    if (hue_q >= HueW'(5 * SectorQ8)) begin
      sec_d = SEC_MAG_RED;
      sbase = HueW'(5 * SectorQ8);
    end else if (hue_q >= HueW'(4 * SectorQ8)) begin
      sec_d = SEC_BLU_MAG;
      sbase = HueW'(4 * SectorQ8);
    end else if (hue_q >= HueW'(3 * SectorQ8)) begin
      sec_d = SEC_CYN_BLU;
      sbase = HueW'(3 * SectorQ8);
    end else if (hue_q >= HueW'(2 * SectorQ8)) begin
      sec_d = SEC_GRN_CYN;
      sbase = HueW'(2 * SectorQ8);
    end else if (hue_q >= HueW'(SectorQ8)) begin
      sec_d = SEC_YEL_GRN;
      sbase = HueW'(SectorQ8);
    end else begin
      sec_d = SEC_RED_YEL;
      sbase = '0;
    end
    h_in = XfW'(hue_q - sbase);
    // Even sectors rise with the hue, odd sectors fall.
    xf_d = sec_d[0] ? (XfW'(SectorQ8) - h_in) : h_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clp_q  <= {clp_q[NumStages-2:0], in_i.clamped};
      inv_q  <= {inv_q[NumStages-2:0], in_i.range_invalid};
      prod_q <= prod_d;
      off_q  <= off_d;
      hsum_q <= hsum_d;
      hue_q  <= hue_d;
      sec_q  <= sec_d;
      xf_q   <= xf_d;
    end
  end

  always_comb begin
    out_o.valid         = vld_q[NumStages-1];
    out_o.sector        = sec_q;
    out_o.xf            = xf_q;
    out_o.clamped       = clp_q[NumStages-1];
    out_o.range_invalid = inv_q[NumStages-1];
  end

endmodule

### design/lvhc_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhc_rgb
// Converts sector and weight with saturation and brightness into 8-bit
// channels; the final division by a constant uses a reciprocal and one
// correction step.
// ----------------------------------------------------------------------------
module lvhc_rgb (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lvhc_pkg::hue_rgb_t in_i,
  input  logic [7:0]         saturation_i,
  input  logic [7:0]         brightness_i,
  output lvhc_pkg::rgb_out_t out_o
);
  import lvhc_pkg::*;

  localparam int NumStages = 5;
  localparam int XpW       = 16 + XfW;
  localparam int RecW      = ChanW + 15;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] clp_q;
  logic [NumStages-1:0] inv_q;

  // Sector rides along until the channel select, the weight until the product.
  sector_e        sec1_q, sec2_q;
  logic [XfW-1:0] xf1_q;

  logic [15:0]            vs_q, vs_d;
  logic [15:0]            vm_q, vm_d;
  logic [XpW-1:0]         xp_q, xp_d;
  logic [ChanW-1:0]       cq_q, cq_d;
  logic [ChanW-1:0]       mq_q, mq_d;
  logic [2:0][ChanW-1:0]  y3_q, y3_d;
  logic [2:0][ChanW-1:0]  y4_q;
  logic [2:0][7:0]        qe_q, qe_d;
  logic [2:0][7:0]        ch_q, ch_d;

  // Stage 1: V*S and V*(255-S).
  always_comb begin
    vs_d = {8'h00, saturation_i} * {8'h00, brightness_i};
    vm_d = {8'h00, 8'd255 - saturation_i} * {8'h00, brightness_i};
  end

  // Stage 2: chroma and offset scaled by 1/1024, secondary unscaled.
  always_comb begin
    xp_d = XpW'(vs_q) * XpW'(xf1_q);
    cq_d = ChanW'(vs_q) * ChanW'(SectorUnit);
    mq_d = ChanW'(vm_q) * ChanW'(SectorUnit);
  end

  // Stage 3: route terms to channels and add the offset.
  always_comb begin
    logic [ChanW-1:0] xq;
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    xq = xp_q[XpW-1:SectorShift];
    case (sec2_q)
      SEC_RED_YEL: begin r = cq_q; g = xq;   b = '0;   end
      SEC_YEL_GRN: begin r = xq;   g = cq_q; b = '0;   end
      SEC_GRN_CYN: begin r = '0;   g = cq_q; b = xq;   end
      SEC_CYN_BLU: begin r = '0;   g = xq;   b = cq_q; end
      SEC_BLU_MAG: begin r = xq;   g = '0;   b = cq_q; end
      default:     begin r = cq_q; g = '0;   b = xq;   end
    endcase
    y3_d[0] = r + mq_q;
    y3_d[1] = g + mq_q;
    y3_d[2] = b + mq_q;
  end

  // Stage 4: quotient estimate, low by at most one.
  always_comb begin
    logic [RecW-1:0] rec;
    for (int c = 0; c < 3; c++) begin
      rec     = RecW'(y3_q[c]) * RecW'(RecipK);
      qe_d[c] = rec[RecipShift+7:RecipShift];
    end
  end

  // Stage 5: correction and saturation.
  always_comb begin
    logic [ChanW-1:0] rem;
    logic [8:0]       q;
    for (int c = 0; c < 3; c++) begin
      rem     = y4_q[c] - ChanW'(qe_q[c]) * ChanW'(ChanDiv);
      q       = (rem >= ChanW'(ChanDiv)) ? ({1'b0, qe_q[c]} + 9'd1) : {1'b0, qe_q[c]};
      ch_d[c] = q[8] ? 8'hFF : q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clp_q  <= {clp_q[NumStages-2:0], in_i.clamped};
      inv_q  <= {inv_q[NumStages-2:0], in_i.range_invalid};
      sec1_q <= in_i.sector;
      xf1_q  <= in_i.xf;
      sec2_q <= sec1_q;
      vs_q   <= vs_d;
      vm_q   <= vm_d;
      xp_q   <= xp_d;
      cq_q   <= cq_d;
      mq_q   <= mq_d;
      y3_q   <= y3_d;
      y4_q   <= y3_q;
      qe_q   <= qe_d;
      ch_q   <= ch_d;
    end
  end

  always_comb begin
    out_o.valid         = vld_q[NumStages-1];
    out_o.red           = ch_q[0];
    out_o.green         = ch_q[1];
    out_o.blue          = ch_q[2];
    out_o.clamped       = clp_q[NumStages-1];
    out_o.range_invalid = inv_q[NumStages-1];
  end

endmodule

### design/level_to_hue_colour_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_to_hue_colour_map
// Colours an unsigned sample by its place in a configured range: the sample
// is normalized, mapped onto a hue span and converted from HSV to RGB with
// configured saturation and brightness. The block accepts one sample beat in
// every clock while it is not stalled and returns one colour beat per
// sample, in order. Pipeline depth is set mostly by the normalizing divider,
// which is a 17-stage pipeline (range check plus one stage per fraction
// bit); five stages follow for the hue span, wrap and sector split, and five
// for the HSV products and the final scaling. The whole pipeline advances as
// one: when a finished beat waits at the output under stall, every stage
// holds, and in_stall_o rises in that same cycle. Registers are written
// through the APB-style port and must only change while no sample is in
// flight; they need no clearing pass and take effect at once after reset.
// ----------------------------------------------------------------------------
module level_to_hue_colour_map #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  // colour channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             red_out_o,
  output logic [7:0]             green_out_o,
  output logic [7:0]             blue_out_o,
  output logic                   clamped_o,
  output logic                   range_invalid_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import lvhc_pkg::*;

  logic [SAMPLE_BITS-1:0] range_low_q;
  logic [SAMPLE_BITS-1:0] range_high_q;
  logic [8:0]             hue_start_q;
  logic [8:0]             hue_end_q;
  logic [7:0]             saturation_q;
  logic [7:0]             brightness_q;

  logic      cfg_wr;
  reg_idx_e  cfg_idx;
  logic      pipe_en;
  norm_hue_t norm_hue;
  hue_rgb_t  hue_rgb;
  rgb_out_t  rgb_out;

  // The register index sits above the two byte-offset bits.
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '1;
      hue_start_q  <= 9'd0;
      hue_end_q    <= 9'd120;
      saturation_q <= 8'd255;
      brightness_q <= 8'd255;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RANGE_LOW:  range_low_q  <= pwdata[SAMPLE_BITS-1:0];
        REG_RANGE_HIGH: range_high_q <= pwdata[SAMPLE_BITS-1:0];
        REG_HUE_START:  hue_start_q  <= pwdata[8:0];
        REG_HUE_END:    hue_end_q    <= pwdata[8:0];
        REG_SATURATION: saturation_q <= pwdata[7:0];
        REG_BRIGHTNESS: brightness_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RANGE_LOW:  prdata = 32'(range_low_q);
      REG_RANGE_HIGH: prdata = 32'(range_high_q);
      REG_HUE_START:  prdata = 32'(hue_start_q);
      REG_HUE_END:    prdata = 32'(hue_end_q);
      REG_SATURATION: prdata = 32'(saturation_q);
      REG_BRIGHTNESS: prdata = 32'(brightness_q);
      default:        prdata = '0;
    endcase
  end

  // A waiting output beat under stall freezes every stage at once.
  assign pipe_en    = !(rgb_out.valid && out_stall_i);
  assign in_stall_o = !pipe_en;

  lvhc_norm #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (in_valid_i),
    .sample_i    (sample_i),
    .range_low_i (range_low_q),
    .range_high_i(range_high_q),
    .out_o       (norm_hue)
  );

  lvhc_hue u_hue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .in_i       (norm_hue),
    .hue_start_i(hue_start_q),
    .hue_end_i  (hue_end_q),
    .out_o      (hue_rgb)
  );

  lvhc_rgb u_rgb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_i        (hue_rgb),
    .saturation_i(saturation_q),
    .brightness_i(brightness_q),
    .out_o       (rgb_out)
  );

  assign out_valid_o     = rgb_out.valid;
  assign red_out_o       = rgb_out.red;
  assign green_out_o     = rgb_out.green;
  assign blue_out_o      = rgb_out.blue;
  assign clamped_o       = rgb_out.clamped;
  assign range_invalid_o = rgb_out.range_invalid;

endmodule

### design/lvhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhc_checker
// Port-level checks of the colour map: output beat hold, the cause of input
// stall and the exclusivity of the two status flags.
// ----------------------------------------------------------------------------
module lvhc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       clamped_o,
  input logic       range_invalid_o
);

  // A stalled colour beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({red_out_o, green_out_o, blue_out_o, clamped_o, range_invalid_o}))
    else $error("stalled colour beat changed or vanished");

  // The input side only stalls because a finished beat is held at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An invalid range never reports a clamped sample.
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_invalid_o |-> !clamped_o)
    else $error("clamped flagged together with an invalid range");

endmodule

bind level_to_hue_colour_map lvhc_checker u_lvhc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .red_out_o      (red_out_o),
  .green_out_o    (green_out_o),
  .blue_out_o     (blue_out_o),
  .clamped_o      (clamped_o),
  .range_invalid_o(range_invalid_o)
);

### verif/tb_level_to_hue_colour_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_level_to_hue_colour_map
// Self-checking bench for the level to hue colour map. A colour predictor
// built from the configuration shadow computes each expected colour beat
// when a sample is accepted. The checker compares every colour beat that
// leaves the block with the oldest prediction, field by field. Directed tests
// cover range clamping, invalid ranges, every hue sector, hue wrap and
// reversed spans, saturation and brightness extremes and writes to unused
// register addresses. Random phases follow with new settings in each phase,
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_level_to_hue_colour_map;
  import lvhc_pkg::*;

  localparam int          Latency    = 27;
  localparam int          DrainExtra = Latency + 8;
  localparam int          LongHold   = 200;
  localparam int          CycleLimit = 500000;
  localparam int unsigned UnusedIdx  = 6;
  localparam longint unsigned FracOne = (64'd1 << FracBits) - 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
    logic       range_invalid;
  } colour_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic [15:0] sample_i        = '0;
  logic        out_stall_i     = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [4:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        clamped_o;
  logic        range_invalid_o;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_range_low  = 16'd0;
  logic [15:0] cfg_range_high = 16'd65535;
  logic [8:0]  cfg_hue_start  = 9'd0;
  logic [8:0]  cfg_hue_end    = 9'd120;
  logic [7:0]  cfg_saturation = 8'd255;
  logic [7:0]  cfg_brightness = 8'd255;

  colour_t     colour_expected[$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned sink_wait    = 0;
  bit          source_quiet = 1'b0;
  bit          sink_quiet   = 1'b0;
  bit          hold_request = 1'b0;

  level_to_hue_colour_map #(
    .SAMPLE_BITS(16)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .clamped_o      (clamped_o),
    .range_invalid_o(range_invalid_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Run limit, far above the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Colour predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] to_channel(input longint unsigned scaled);
    longint unsigned q;
    q = scaled / (255 * SectorQ8);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic colour_t predict_colour(input logic [15:0] level);
    longint unsigned lvl, lo, hi, frac, hs, he, hue, t;
    longint unsigned v, sat, c_n, x_n, m_n, r, g, b;
    sector_e         sector;
    colour_t         res;
    lvl  = level;
    lo   = cfg_range_low;
    hi   = cfg_range_high;
    hs   = cfg_hue_start;
    he   = cfg_hue_end;
    v    = cfg_brightness;
    sat  = cfg_saturation;
    res  = '0;
    frac = 0;
    // Normalize into the range; an empty or inverted range only raises the flag.
    if (hi <= lo) begin
      res.range_invalid = 1'b1;
    end else if (lvl < lo) begin
      res.clamped = 1'b1;
    end else if (lvl > hi) begin
      res.clamped = 1'b1;
      frac        = FracOne;
    end else begin
      frac = ((lvl - lo) * FracOne) / (hi - lo);
    end
    // The hue offset is truncated toward the start hue in either direction.
    if (he >= hs) begin
      hue = hs * 256 + ((he - hs) * 256 * frac) / FracOne;
    end else begin
      hue = hs * 256 - ((hs - he) * 256 * frac) / FracOne;
    end
    hue    = hue % FullTurnQ8;
    sector = sector_e'(3'(hue / SectorQ8));
    t      = hue % (2 * SectorQ8);
    t      = (t >= SectorQ8) ? t - SectorQ8 : SectorQ8 - t;
    c_n    = v * sat * SectorQ8;
    x_n    = v * sat * (SectorQ8 - t);
    m_n    = v * (255 - sat) * SectorQ8;
    case (sector)
      SEC_RED_YEL: begin r = c_n; g = x_n; b = 0;   end
      SEC_YEL_GRN: begin r = x_n; g = c_n; b = 0;   end
      SEC_GRN_CYN: begin r = 0;   g = c_n; b = x_n; end
      SEC_CYN_BLU: begin r = 0;   g = x_n; b = c_n; end
      SEC_BLU_MAG: begin r = x_n; g = 0;   b = c_n; end
      default:     begin r = c_n; g = 0;   b = x_n; end
    endcase
    res.red   = to_channel(r + m_n);
    res.green = to_channel(g + m_n);
    res.blue  = to_channel(b + m_n);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Colour checker: every accepted colour beat against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    colour_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sink_wait = sink_quiet ? 0 : $urandom_range(0, 13);
      if (colour_expected.size() == 0) begin
        mismatches++;
        $display("%0t: colour beat with nothing expected, got %0d %0d %0d %0b %0b",
                 $time, red_out_o, green_out_o, blue_out_o, clamped_o,
                 range_invalid_o);
      end else begin
        want = colour_expected.pop_front();
        check_field("red", want.red, red_out_o);
        check_field("green", want.green, green_out_o);
        check_field("blue", want.blue, blue_out_o);
        check_field("clamped", want.clamped, clamped_o);
        check_field("range_invalid", want.range_invalid, range_invalid_o);
      end
    end
  end

  // Colour sink: a per-beat stall count, or one long hold-off on request.
  initial begin : colour_sink
    int unsigned held;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < LongHold; held++) @(negedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (sink_wait > 0) begin
        out_stall_i <= 1'b1;
        sink_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample source and register access
  // --------------------------------------------------------------------------
  // Sends one sample beat. Valid stays high on return so that the next beat
  // can follow back to back; release_source lowers it.
  task automatic send_sample(input logic [15:0] level);
    int unsigned gap;
    gap = source_quiet ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= level;
    do @(posedge clk_i); while (in_stall_o);
    colour_expected.push_back(predict_colour(level));
  endtask

  task automatic release_source();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every predicted colour has come out and the pipeline is empty.
  task automatic wait_drained();
    release_source();
    while (colour_expected.size() != 0) @(posedge clk_i);
    repeat (DrainExtra) @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      int'(REG_RANGE_LOW):  cfg_range_low  = data[15:0];
      int'(REG_RANGE_HIGH): cfg_range_high = data[15:0];
      int'(REG_HUE_START):  cfg_hue_start  = data[8:0];
      int'(REG_HUE_END):    cfg_hue_end    = data[8:0];
      int'(REG_SATURATION): cfg_saturation = data[7:0];
      int'(REG_BRIGHTNESS): cfg_brightness = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Half of the random writes carry junk above the register width.
  function automatic logic [31:0] with_noise(input int unsigned value,
                                             input int unsigned width);
    logic [31:0] junk;
    junk = $urandom();
    if ($urandom_range(0, 1) == 0) return value;
    return (junk << width) | value;
  endfunction

  function automatic int unsigned pick_hue();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 359;
      2:       return $urandom_range(360, 511);
      default: return $urandom_range(0, 359);
    endcase
  endfunction

  function automatic int unsigned pick_level8();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Samples that land in, near or outside the range, with plain noise besides.
  function automatic logic [15:0] pick_sample();
    int unsigned lo, hi;
    lo = cfg_range_low;
    hi = cfg_range_high;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom());
      4, 5, 6: begin
        if (hi > lo) return 16'($urandom_range(lo, hi));
        return 16'($urandom());
      end
      7: begin
        case ($urandom_range(0, 5))
          0:       return 16'(lo - 1);
          1:       return 16'(lo);
          2:       return 16'(lo + 1);
          3:       return 16'(hi - 1);
          4:       return 16'(hi);
          default: return 16'(hi + 1);
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'd0;
          1:       return 16'hFFFF;
          2:       return (lo > 0) ? 16'($urandom_range(0, lo - 1)) : 16'd0;
          default: return (hi < 65535) ? 16'($urandom_range(hi + 1, 65535)) : 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic randomize_config();
    int unsigned lo, hi;
    case ($urandom_range(0, 6))
      0: begin lo = 0; hi = 65535; end
      1: begin
        lo = $urandom_range(0, 65519);
        hi = lo + $urandom_range(1, 16);
      end
      2: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
      3: begin lo = $urandom_range(0, 65535); hi = lo; end
      4: begin lo = $urandom_range(1, 65535); hi = $urandom_range(0, lo - 1); end
      5: begin
        lo = $urandom_range(0, 1) ? 0 : 65534;
        hi = lo + 1;
      end
      default: begin lo = $urandom_range(0, 30000); hi = $urandom_range(35000, 65535); end
    endcase
    write_reg(REG_RANGE_LOW, with_noise(lo, 16));
    write_reg(REG_RANGE_HIGH, with_noise(hi, 16));
    write_reg(REG_HUE_START, with_noise(pick_hue(), 9));
    write_reg(REG_HUE_END, with_noise(pick_hue(), 9));
    write_reg(REG_SATURATION, with_noise(pick_level8(), 8));
    write_reg(REG_BRIGHTNESS, with_noise(pick_level8(), 8));
    if ($urandom_range(0, 7) == 0) write_reg(UnusedIdx + $urandom_range(0, 1), $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: full sample range onto 0..120 degrees.
  task automatic test_reset_values();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h8000);
  endtask

  // Samples on and just outside both ends of a narrow range, and its middle.
  task automatic test_range_clamp();
    wait_drained();
    write_reg(REG_RANGE_LOW, 1000);
    write_reg(REG_RANGE_HIGH, 2000);
    send_sample(16'd999);
    send_sample(16'd1000);
    send_sample(16'd1500);
    send_sample(16'd2000);
    send_sample(16'd2001);
  endtask

  // An empty range and an inverted one give fraction zero and no clamp flag.
  task automatic test_invalid_range();
    wait_drained();
    write_reg(REG_RANGE_LOW, 500);
    write_reg(REG_RANGE_HIGH, 500);
    send_sample(16'd500);
    wait_drained();
    write_reg(REG_RANGE_HIGH, 499);
    send_sample(16'd0);
  endtask

  // Full circle of hue, one sample in the middle of each 60 degree sector.
  task automatic test_hue_sectors();
    int unsigned k;
    wait_drained();
    write_reg(REG_RANGE_LOW, 0);
    write_reg(REG_RANGE_HIGH, 65535);
    write_reg(REG_HUE_START, 0);
    write_reg(REG_HUE_END, 359);
    for (k = 0; k < 6; k++) send_sample(16'(((30 + 60 * k) * 65535) / 359));
  endtask

  // Start hue above a full turn and a span running downward.
  task automatic test_hue_wrap_reverse();
    wait_drained();
    write_reg(REG_HUE_START, 511);
    write_reg(REG_HUE_END, 0);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
  endtask

  task automatic test_sat_bright_extremes();
    wait_drained();
    write_reg(REG_HUE_START, 200);
    write_reg(REG_HUE_END, 20);
    write_reg(REG_SATURATION, 0);
    send_sample(16'd20000);
    wait_drained();
    write_reg(REG_SATURATION, 255);
    write_reg(REG_BRIGHTNESS, 0);
    send_sample(16'd40000);
  endtask

  // Writes past the last register must leave the settings alone.
  task automatic test_unused_address();
    wait_drained();
    write_reg(REG_BRIGHTNESS, 180);
    write_reg(UnusedIdx, 32'hFFFF_FFFF);
    write_reg(UnusedIdx + 1, 32'hFFFF_FFFF);
    send_sample(16'd30000);
  endtask

  // New settings and a new idling pattern in each phase.
  task automatic test_random_phases();
    int unsigned phase, n;
    for (phase = 0; phase < 16; phase++) begin
      wait_drained();
      randomize_config();
      source_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 118; n++) send_sample(pick_sample());
    end
    source_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  // Hold the colour side off for a long time while samples keep coming, so
  // the pipeline fills and the sample side has to stall.
  task automatic test_back_pressure();
    int unsigned n;
    wait_drained();
    randomize_config();
    source_quiet = 1'b1;
    hold_request = 1'b1;
    for (n = 0; n < 80; n++) send_sample(pick_sample());
    source_quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_range_clamp();
    test_invalid_range();
    test_hue_sectors();
    test_hue_wrap_reverse();
    test_sat_bright_extremes();
    test_unused_address();
    test_random_phases();
    test_back_pressure();
    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/lvhc_pkg.sv
design/lvhc_norm.sv
design/lvhc_hue.sv
design/lvhc_rgb.sv
design/level_to_hue_colour_map.sv
design/lvhc_checker.sv
verif/tb_level_to_hue_colour_map.sv
